/* hdl/dmpid_pkg.sv */
// Package for the dual-mode PID controller: widths, register and mode codes,
// the configuration struct, and the Q8.8 multiply and magnitude-clamp helpers.
// Depends on nothing; every other file in hdl/ imports it.
package dmpid_pkg;

  // Sample and gain formats.
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 31;
  localparam int DRIVE_W        = 32;

  // Error and difference widths: e, first difference, second difference.
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIF1_W = ERR_W + 1;
  localparam int DIF2_W = ERR_W + 2;

  // Exact product width and the accumulator width for sums of up to four terms.
  localparam int PROD_W = GAIN_W + DIF2_W;
  localparam int ACC_W  = ((PROD_W > DRIVE_W) ? PROD_W : DRIVE_W) + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALGORITHM = 3'd0,
    CFG_KP_GAIN   = 3'd1,
    CFG_KI_GAIN   = 3'd2,
    CFG_KD_GAIN   = 3'd3,
    CFG_OUT_LIMIT = 3'd4,
    CFG_INT_LIMIT = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    ALG_POSITIONAL  = 1'b0,
    ALG_INCREMENTAL = 1'b1
  } alg_t;

  typedef enum logic {
    MODE_STEP  = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    alg_t                      alg;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0]        out_limit;
    logic [LIMIT_W-1:0]        int_limit;
  } cfg_t;

  // Exact gain times difference, then arithmetic shift (rounds toward minus infinity).
  function automatic logic signed [PROD_W-1:0] gain_mul(
    input logic signed [GAIN_W-1:0] gain,
    input logic signed [DIF2_W-1:0] diff
  );
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(gain) * PROD_W'(diff);
    return prod >>> GAIN_FRAC_BITS;
  endfunction

  // Clamp a value to plus or minus a non-negative limit.
  function automatic logic signed [ACC_W-1:0] clamp_mag(
    input logic signed [ACC_W-1:0] x,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed(ACC_W'(lim));
    lo = -hi;
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

endpackage

/* hdl/dual_mode_pid_controller.sv */
// Top level of the dual-mode (positional / incremental) PID controller:
// input register, output register and handshakes around dmpid_core and dmpid_cfg_regs.
// Depends on dmpid_pkg, dmpid_cfg_regs and dmpid_core.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_stall    in_mode, in_setpoint, in_feedback
//   out_*     output     out_valid / out_stall  out_drive_out
//   cfg_*     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while out_stall is low; an item passes the input register,
// then the single arithmetic pass into the output register, which also updates the state.
// The multiply, add and clamp path between the two registers sets the clock.
// rst_n is synchronous: it empties both registers and zeroes state and config.
// in_stall rises only while the input register is full and cannot move on,
// which happens when the output register holds a result under out_stall.
module dual_mode_pid_controller (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      in_mode,
  input  logic signed [dmpid_pkg::SAMPLE_WIDTH-1:0] in_setpoint,
  input  logic signed [dmpid_pkg::SAMPLE_WIDTH-1:0] in_feedback,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [dmpid_pkg::DRIVE_W-1:0]      out_drive_out,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [dmpid_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [dmpid_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import dmpid_pkg::*;

  cfg_t cfg;

  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_mode_r;
  logic signed [SAMPLE_WIDTH-1:0]  s1_sp_r;
  logic signed [SAMPLE_WIDTH-1:0]  s1_fb_r;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0]       out_drive_r;
  logic signed [DRIVE_W-1:0]       drive_nxt;
  logic                            advance;
  logic                            in_xfer;

  dmpid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmpid_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .mode      (s1_mode_r),
    .setpoint  (s1_sp_r),
    .feedback  (s1_fb_r),
    .drive_nxt (drive_nxt)
  );

  // The held item moves on when the output register is empty or being drained.
  always_comb begin
    advance       = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall      = s1_valid_r && !advance;
    in_xfer       = in_valid && !in_stall;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  assign out_valid     = out_valid_r;
  assign out_drive_out = out_drive_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r <= in_mode;
      s1_sp_r   <= in_setpoint;
      s1_fb_r   <= in_feedback;
    end
    if (advance) begin
      out_drive_r <= drive_nxt;
    end
  end

  // An item that could not move on is still held next cycle, unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_sp_r) && $stable(s1_fb_r))
    else $error("input register lost a held item");

  // Every step produces a result in the output register.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("step produced no result");

  // No new item enters while the held one is blocked.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !s1_valid_r || advance)
    else $error("input register overrun");

endmodule

/* hdl/dmpid_cfg_regs.sv */
// Configuration register file of the PID controller: algorithm, gains, limits.
// Depends on dmpid_pkg.
module dmpid_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmpid_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dmpid_pkg::cfg_t                    cfg
);
  import dmpid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode one write transfer.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALGORITHM: cfg_nxt.alg       = alg_t'(cfg_data[0]);
        CFG_KP_GAIN:   cfg_nxt.kp        = $signed(cfg_data[GAIN_W-1:0]);
        CFG_KI_GAIN:   cfg_nxt.ki        = $signed(cfg_data[GAIN_W-1:0]);
        CFG_KD_GAIN:   cfg_nxt.kd        = $signed(cfg_data[GAIN_W-1:0]);
        CFG_OUT_LIMIT: cfg_nxt.out_limit = cfg_data[LIMIT_W-1:0];
        CFG_INT_LIMIT: cfg_nxt.int_limit = cfg_data[LIMIT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/dmpid_core.sv */
// PID datapath and controller state: error history, integral, held output.
// One step per cycle while step is high; three gain multipliers feed adders and clamps.
// Depends on dmpid_pkg.
module dmpid_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dmpid_pkg::cfg_t                          cfg,
  input  logic                                     step,
  input  logic                                     mode,
  input  logic signed [dmpid_pkg::SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [dmpid_pkg::SAMPLE_WIDTH-1:0] feedback,
  output logic signed [dmpid_pkg::DRIVE_W-1:0]     drive_nxt
);
  import dmpid_pkg::*;

  logic signed [ERR_W-1:0]   err_last_r, err_last_nxt;
  logic signed [ERR_W-1:0]   err_prev_r, err_prev_nxt;
  logic signed [DRIVE_W-1:0] isum_r, isum_nxt;
  logic signed [DRIVE_W-1:0] held_r, held_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [DIF1_W-1:0]  dif1;
  logic signed [DIF2_W-1:0]  dif2;
  logic signed [DIF2_W-1:0]  kp_x;
  logic signed [DIF2_W-1:0]  kd_x;
  logic signed [PROD_W-1:0]  p_term;
  logic signed [PROD_W-1:0]  i_term;
  logic signed [PROD_W-1:0]  d_term;
  logic signed [ACC_W-1:0]   isum_clamped;
  logic signed [ACC_W-1:0]   pos_out;
  logic signed [ACC_W-1:0]   inc_out;
  logic                      is_inc;
  logic                      is_clear;

  assign is_inc   = (cfg.alg == ALG_INCREMENTAL);
  assign is_clear = (mode == MODE_CLEAR);

  // Error and its first and second differences.
  always_comb begin
    err  = ERR_W'(setpoint) - ERR_W'(feedback);
    dif1 = DIF1_W'(err) - DIF1_W'(err_last_r);
    dif2 = DIF2_W'(err) - (DIF2_W'(err_last_r) <<< 1) + DIF2_W'(err_prev_r);
  end

  // Multiplier operands depend on the algorithm; Ki always sees the error.
  always_comb begin
    kp_x   = is_inc ? DIF2_W'(dif1) : DIF2_W'(err);
    kd_x   = is_inc ? dif2 : DIF2_W'(dif1);
    p_term = gain_mul(cfg.kp, kp_x);
    i_term = gain_mul(cfg.ki, DIF2_W'(err));
    d_term = gain_mul(cfg.kd, kd_x);
  end

  // Positional sum with clamped integral, and incremental accumulation.
  always_comb begin
    isum_clamped = clamp_mag(ACC_W'(isum_r) + ACC_W'(i_term), cfg.int_limit);
    pos_out      = clamp_mag(ACC_W'(p_term) + isum_clamped + ACC_W'(d_term),
                             cfg.out_limit);
    inc_out      = clamp_mag(ACC_W'(held_r) + ACC_W'(p_term) + ACC_W'(i_term)
                             + ACC_W'(d_term), cfg.out_limit);
  end

  // Next state; a clear zeroes everything.
  always_comb begin
    if (is_clear) begin
      err_last_nxt = '0;
      err_prev_nxt = '0;
      isum_nxt     = '0;
      held_nxt     = '0;
    end else begin
      err_last_nxt = err;
      err_prev_nxt = err_last_r;
      if (is_inc) begin
        isum_nxt = DRIVE_W'(i_term);
        held_nxt = DRIVE_W'(inc_out);
      end else begin
        isum_nxt = DRIVE_W'(isum_clamped);
        held_nxt = DRIVE_W'(pos_out);
      end
    end
    drive_nxt = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_last_r <= '0;
      err_prev_r <= '0;
      isum_r     <= '0;
      held_r     <= '0;
    end else if (step) begin
      err_last_r <= err_last_nxt;
      err_prev_r <= err_prev_nxt;
      isum_r     <= isum_nxt;
      held_r     <= held_nxt;
    end
  end

  // A clear step leaves all state at zero.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_clear |=> err_last_r == '0 && err_prev_r == '0 && isum_r == '0
                         && held_r == '0)
    else $error("state not zero after clear");

  // The drive stays inside the output limit.
  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (ACC_W'(drive_nxt) <= $signed(ACC_W'(cfg.out_limit)))
          && (ACC_W'(drive_nxt) >= -$signed(ACC_W'(cfg.out_limit))))
    else $error("drive exceeds output limit");

  // A control step shifts the error history by one place.
  a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_clear |=> err_prev_r == $past(err_last_r))
    else $error("error history not shifted");

endmodule

/* tb/sv/dual_mode_pid_controller_tb.sv */
// Self-checking testbench for dual_mode_pid_controller: a directed table, then random
// control steps under several gain and limit settings, scored against a PID predictor.
// Depends on dmpid_pkg and the dual_mode_pid_controller RTL.
`timescale 1ns / 1ps

module dual_mode_pid_controller_tb;
  import dmpid_pkg::*;

  // Unmapped register indexes; writes to them must leave the controller unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int QUIET_LIMIT = 5000;
  localparam int DIR_ROWS    = 20;
  localparam int DIR_SETS    = 6;
  localparam int PHASES      = 3;
  localparam int BLOCKS      = 10;
  localparam int BLOCK_ITEMS = 62;

  // One full register image, one word per register index.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] alg;
    logic [CFG_DATA_W-1:0] kp;
    logic [CFG_DATA_W-1:0] ki;
    logic [CFG_DATA_W-1:0] kd;
    logic [CFG_DATA_W-1:0] out_lim;
    logic [CFG_DATA_W-1:0] int_lim;
  } reg_image_t;

  // One row of the directed table.
  typedef struct packed {
    int                              setting;
    mode_t                           mode;
    logic signed [SAMPLE_WIDTH-1:0]  sp;
    logic signed [SAMPLE_WIDTH-1:0]  fb;
    logic                            known;
    logic signed [DRIVE_W-1:0]       drive;
  } dir_row_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_mode = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0]    in_setpoint = '0;
  logic signed [SAMPLE_WIDTH-1:0]    in_feedback = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]         out_drive_out;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index = '0;
  logic [CFG_DATA_W-1:0]             cfg_data = '0;

  // Idle knobs for the two sides, in percent of cycles.
  int send_pct  = 0;
  int stall_pct = 0;

  int fail_count  = 0;
  int quiet_cycles = 0;

  logic signed [DRIVE_W-1:0] drive_expected [$];

  // Predictor copy of the registers and the controller state.
  alg_t   alg_sel   = ALG_POSITIONAL;
  longint gain_p    = 0;
  longint gain_i    = 0;
  longint gain_d    = 0;
  longint drive_lim = 0;
  longint integ_lim = 0;
  longint err_prev1 = 0;
  longint err_prev2 = 0;
  longint integ_acc = 0;
  longint drive_acc = 0;

  dual_mode_pid_controller DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_setpoint   (in_setpoint),
    .in_feedback   (in_feedback),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_out (out_drive_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude clamp against a non-negative limit.
  function automatic longint saturate(longint x, longint lim);
    if (x > lim) begin
      return lim;
    end
    if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  // Mirror a register write into the predictor.
  function automatic void track_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ALGORITHM: alg_sel   = alg_t'(d[0]);
      CFG_KP_GAIN:   gain_p    = longint'($signed(d[GAIN_W-1:0]));
      CFG_KI_GAIN:   gain_i    = longint'($signed(d[GAIN_W-1:0]));
      CFG_KD_GAIN:   gain_d    = longint'($signed(d[GAIN_W-1:0]));
      CFG_OUT_LIMIT: drive_lim = longint'({1'b0, d[LIMIT_W-1:0]});
      CFG_INT_LIMIT: integ_lim = longint'({1'b0, d[LIMIT_W-1:0]});
      default: ;
    endcase
  endfunction

  // One controller step: updates the predictor state and returns the drive output.
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    mode_t m, logic signed [SAMPLE_WIDTH-1:0] sp, logic signed [SAMPLE_WIDTH-1:0] fb);
    longint e;
    longint tp;
    longint ti;
    longint td;
    if (m == MODE_CLEAR) begin
      err_prev1 = 0;
      err_prev2 = 0;
      integ_acc = 0;
      drive_acc = 0;
      return '0;
    end
    e = longint'(sp) - longint'(fb);
    if (alg_sel == ALG_POSITIONAL) begin
      tp = (gain_p * e) >>> GAIN_FRAC_BITS;
      ti = (gain_i * e) >>> GAIN_FRAC_BITS;
      td = (gain_d * (e - err_prev1)) >>> GAIN_FRAC_BITS;
      integ_acc = saturate(integ_acc + ti, integ_lim);
      drive_acc = saturate(tp + integ_acc + td, drive_lim);
    end else begin
      tp = (gain_p * (e - err_prev1)) >>> GAIN_FRAC_BITS;
      ti = (gain_i * e) >>> GAIN_FRAC_BITS;
      td = (gain_d * (e - 2 * err_prev1 + err_prev2)) >>> GAIN_FRAC_BITS;
      // The incremental path keeps only this step's integral term, unclamped.
      integ_acc = ti;
      drive_acc = saturate(drive_acc + tp + ti + td, drive_lim);
    end
    err_prev2 = err_prev1;
    err_prev1 = e;
    return DRIVE_W'(drive_acc);
  endfunction

  // Random gain word: extremes, small gains or anything, with junk in the upper bits.
  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(3))
      0:       g = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      1:       g = GAIN_W'(int'($urandom_range(1024)) - 512);
      default: g = GAIN_W'($urandom);
    endcase
    return {16'($urandom), g};
  endfunction

  // Random limit word: zero, full scale, small or anything, with a junk top bit.
  function automatic logic [CFG_DATA_W-1:0] rand_limit();
    logic [LIMIT_W-1:0] l;
    case ($urandom_range(3))
      0:       l = '0;
      1:       l = '1;
      2:       l = LIMIT_W'($urandom_range(5000));
      default: l = LIMIT_W'($urandom);
    endcase
    return {1'($urandom), l};
  endfunction

  // Register image for a random block; the first two flavors pin the extremes.
  function automatic reg_image_t rand_setting(int flavor);
    reg_image_t s;
    s.alg = $urandom;
    case (flavor)
      0: begin
        s.kp = 32'h0000_7FFF;
        s.ki = 32'h0000_7FFF;
        s.kd = 32'h0000_7FFF;
        s.out_lim = 32'h7FFF_FFFF;
        s.int_lim = 32'h7FFF_FFFF;
      end
      1: begin
        s.kp = 32'hFFFF_8000;
        s.ki = 32'hFFFF_8000;
        s.kd = 32'hFFFF_8000;
        s.out_lim = 32'h8000_0000;
        s.int_lim = 32'h0000_0000;
      end
      default: begin
        s.kp = rand_gain();
        s.ki = rand_gain();
        s.kd = rand_gain();
        s.out_lim = rand_limit();
        s.int_lim = rand_limit();
      end
    endcase
    return s;
  endfunction

  // Random sample: a rail, a value near zero, or anything.
  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(3))
      0:       return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      1:       return SAMPLE_WIDTH'(int'($urandom_range(400)) - 200);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Register write; cfg_valid is left high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track_reg_write(idx, d);
  endtask

  // Write every register, optionally followed by a write to an unmapped index.
  task automatic load_settings(reg_image_t s, bit spare);
    logic [CFG_IDX_W-1:0] spare_idx;
    write_reg(CFG_ALGORITHM, s.alg);
    write_reg(CFG_KP_GAIN, s.kp);
    write_reg(CFG_KI_GAIN, s.ki);
    write_reg(CFG_KD_GAIN, s.kd);
    write_reg(CFG_OUT_LIMIT, s.out_lim);
    write_reg(CFG_INT_LIMIT, s.int_lim);
    if (spare) begin
      spare_idx = ($urandom_range(1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
      write_reg(spare_idx, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain the pipeline before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one item, wait for its transfer, and queue the drive value it must produce.
  task automatic send_item(mode_t m, logic signed [SAMPLE_WIDTH-1:0] sp,
                           logic signed [SAMPLE_WIDTH-1:0] fb, bit known,
                           logic signed [DRIVE_W-1:0] known_drive);
    logic signed [DRIVE_W-1:0] predicted;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_setpoint <= sp;
    in_feedback <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_drive(m, sp, fb);
    drive_expected.push_back(known ? known_drive : predicted);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Score every result transfer against the oldest expectation.
  always @(posedge clk) begin : drive_check
    logic signed [DRIVE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_expected.size() == 0) begin
        $error("drive_out transfer with nothing expected: actual %0d", out_drive_out);
        fail_count++;
      end else begin
        want = drive_expected.pop_front();
        if (out_drive_out !== want) begin
          $error("drive_out mismatch: expected %0d, actual %0d", want, out_drive_out);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    dir_row_t   dir_rows [DIR_ROWS];
    reg_image_t dir_sets [DIR_SETS];
    int         cur_set;
    mode_t      m;

    // Directed settings; set 0 is the reset state and is never written.
    dir_sets[0] = '0;
    dir_sets[1] = '{32'd0, 32'h0000_0100, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    dir_sets[2] = '{32'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF};
    dir_sets[3] = '{32'd1, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'd1000, 32'd5};
    dir_sets[4] = '{32'd0, 32'd0, 32'h0000_0100, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    dir_sets[5] = '{32'd0, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 32'd0, 32'd0};

    // After reset all gains and limits are zero, so the drive stays at zero.
    dir_rows[0]  = '{0, MODE_STEP,  16'sh7FFF, 16'sh8000, 1'b1, 32'sd0};
    dir_rows[1]  = '{0, MODE_STEP,  16'sh8000, 16'sh7FFF, 1'b1, 32'sd0};
    dir_rows[2]  = '{0, MODE_CLEAR, 16'sh0000, 16'sh0000, 1'b1, 32'sd0};
    // Unity proportional gain alone passes the error straight through.
    dir_rows[3]  = '{1, MODE_STEP,  16'sd100,  16'sd40,   1'b1, 32'sd60};
    dir_rows[4]  = '{1, MODE_STEP,  -16'sd5,   16'sd0,    1'b1, -32'sd5};
    dir_rows[5]  = '{1, MODE_STEP,  16'sd0,    16'sd0,    1'b1, 32'sd0};
    // Most negative gains on full-scale errors give the largest products.
    dir_rows[6]  = '{2, MODE_STEP,  16'sh7FFF, 16'sh8000, 1'b0, 32'sd0};
    dir_rows[7]  = '{2, MODE_STEP,  16'sh7FFF, 16'sh8000, 1'b0, 32'sd0};
    dir_rows[8]  = '{2, MODE_STEP,  16'sh8000, 16'sh7FFF, 1'b0, 32'sd0};
    dir_rows[9]  = '{2, MODE_CLEAR, 16'shFFFF, 16'shFFFF, 1'b1, 32'sd0};
    dir_rows[10] = '{2, MODE_STEP,  16'sh8000, 16'sh7FFF, 1'b0, 32'sd0};
    // Incremental steps; the last one leaves a large unclamped integral term.
    dir_rows[11] = '{3, MODE_STEP,  16'sd1000, 16'sd0,    1'b0, 32'sd0};
    dir_rows[12] = '{3, MODE_STEP,  16'sd0,    16'sd0,    1'b0, 32'sd0};
    dir_rows[13] = '{3, MODE_STEP,  -16'sd1000, 16'sd0,   1'b0, 32'sd0};
    dir_rows[14] = '{3, MODE_STEP,  16'sh7FFF, 16'sh8000, 1'b0, 32'sd0};
    // Positional steps pick up the integral that the incremental path left.
    dir_rows[15] = '{4, MODE_STEP,  16'sd10,   16'sd0,    1'b0, 32'sd0};
    dir_rows[16] = '{4, MODE_STEP,  16'sd10,   16'sd0,    1'b0, 32'sd0};
    // Zero limits hold the output at zero whatever the error.
    dir_rows[17] = '{5, MODE_STEP,  16'sh7FFF, 16'sh8000, 1'b1, 32'sd0};
    dir_rows[18] = '{5, MODE_STEP,  16'sh8000, 16'sh7FFF, 1'b1, 32'sd0};
    dir_rows[19] = '{5, MODE_CLEAR, 16'sd12345, 16'shFFFF, 1'b1, 32'sd0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, under the first idle pattern.
    send_pct  = 18;
    stall_pct = 82;
    cur_set   = 0;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].setting != cur_set) begin
        settle();
        load_settings(dir_sets[dir_rows[r].setting], 1'b0);
        cur_set = dir_rows[r].setting;
      end
      send_item(dir_rows[r].mode, dir_rows[r].sp, dir_rows[r].fb,
                dir_rows[r].known, dir_rows[r].drive);
    end

    // Random blocks: each idle pattern runs through a series of register settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin send_pct = 18; stall_pct = 82; end
        1:       begin send_pct = 82; stall_pct = 18; end
        default: begin send_pct = 0;  stall_pct = 0;  end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        settle();
        load_settings(rand_setting(blk), blk == 2);
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          m = ($urandom_range(99) < 3) ? MODE_CLEAR : MODE_STEP;
          send_item(m, rand_sample(), rand_sample(), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then give stray results a chance to show up.
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
